// File: src/wzht_pkg.sv
// Shared types and codes for the window z-order hit test block.
// Holds the opcode and status codes, the rectangle record and default sizes.
// No dependencies.
package wzht_pkg;

    localparam int MAX_WINDOWS_DEF = 16;

    localparam int OPC_W    = 3;
    localparam int SLOT_W   = 4;
    localparam int COORD_W  = 12;
    localparam int SIZE_W   = 11;
    localparam int STATUS_W = 2;

    localparam logic [OPC_W-1:0] OP_HIT    = 3'd0;
    localparam logic [OPC_W-1:0] OP_CREATE = 3'd1;
    localparam logic [OPC_W-1:0] OP_LIFT   = 3'd2;
    localparam logic [OPC_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } t_rect;

endpackage

// File: src/window_zorder_hit_test_top.sv
// Window stack with z-order and point hit test, run by a small sequencer.
// The stacking order and the rectangles live in two memories with registered reads.
// Depends on wzht_pkg.
// A hit test visits the windows from the top of the stack down until one holds the point.
// A create scans the slots upward from slot 1 for the lowest free one.
// Lift/remove find the target and shift the stack above it down; clear keeps only the root.
// One item is in work at a time, and a new one is accepted once the result is registered.
// Reset is synchronous and leaves only the root window; no memory clearing pass is needed.
module window_zorder_hit_test_top
    import wzht_pkg::*;
#(
    parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [OPC_W-1:0]           i_opcode,
    input  logic [SLOT_W-1:0]          i_slot,
    input  logic signed [COORD_W-1:0]  i_coord_x,
    input  logic signed [COORD_W-1:0]  i_coord_y,
    input  logic [SIZE_W-1:0]          i_size_w,
    input  logic [SIZE_W-1:0]          i_size_h,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic                       o_hit,
    output logic [SLOT_W-1:0]          o_result_slot
);

    localparam int SW = $clog2(MAX_WINDOWS);
    localparam int CW = SW + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HT_Z = 4'd1;
    localparam logic [3:0] S_HT_R = 4'd2;
    localparam logic [3:0] S_HT_C = 4'd3;
    localparam logic [3:0] S_CR   = 4'd4;
    localparam logic [3:0] S_FD_Z = 4'd5;
    localparam logic [3:0] S_FD_C = 4'd6;
    localparam logic [3:0] S_SH_R = 4'd7;
    localparam logic [3:0] S_SH_W = 4'd8;
    localparam logic [3:0] S_SH_F = 4'd9;
    localparam logic [3:0] S_RESP = 4'd10;

    logic [3:0]                r_state, n_state;
    logic [SW-1:0]             r_idx, n_idx;
    logic [CW-1:0]             r_count, n_count;
    logic [MAX_WINDOWS-1:0]    r_used, n_used;
    logic [OPC_W-1:0]          r_op, n_op;
    logic [SW-1:0]             r_tgt, n_tgt;
    t_rect                     r_new, n_new;
    logic [STATUS_W-1:0]       r_res_status, n_res_status;
    logic                      r_res_hit, n_res_hit;
    logic [SW-1:0]             r_res_slot, n_res_slot;
    logic                      r_ovalid;
    logic [STATUS_W-1:0]       r_ostatus;
    logic                      r_ohit;
    logic [SLOT_W-1:0]         r_oslot;

    logic [SW-1:0]             r_zq;
    t_rect                     r_rq;
    logic [SW-1:0]             zmem [MAX_WINDOWS];
    t_rect                     rmem [MAX_WINDOWS];

    logic                      w_accept;
    logic                      w_out_free;
    logic                      w_tgt_bad;
    logic                      w_more;
    logic                      w_inside;
    logic signed [COORD_W:0]   w_x_end;
    logic signed [COORD_W:0]   w_y_end;
    logic                      w_z_re;
    logic                      w_r_re;
    logic [SW-1:0]             w_z_raddr;
    logic                      w_z_we;
    logic [SW-1:0]             w_z_waddr;
    logic [SW-1:0]             w_z_wdata;
    logic                      w_r_we;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_ovalid || !i_stall;

    assign w_tgt_bad = (i_slot == '0) || (32'(i_slot) >= MAX_WINDOWS) ||
                       !r_used[SW'(i_slot)];
    assign w_more    = ((CW'(r_idx) + CW'(1)) < r_count);

    assign w_x_end  = $signed({r_rq.x0[COORD_W-1], r_rq.x0}) + $signed({2'b00, r_rq.w});
    assign w_y_end  = $signed({r_rq.y0[COORD_W-1], r_rq.y0}) + $signed({2'b00, r_rq.h});
    assign w_inside = (r_rq.x0 <= r_new.x0) &&
                      ($signed({r_new.x0[COORD_W-1], r_new.x0}) <= w_x_end) &&
                      (r_rq.y0 <= r_new.y0) &&
                      ($signed({r_new.y0[COORD_W-1], r_new.y0}) <= w_y_end);

    always_comb begin
        w_z_re    = 1'b0;
        w_r_re    = 1'b0;
        w_z_raddr = r_idx;
        w_z_we    = 1'b0;
        w_z_waddr = r_idx;
        w_z_wdata = r_zq;
        w_r_we    = 1'b0;
        case (r_state)
            S_HT_Z, S_FD_Z: begin
                w_z_re = 1'b1;
            end
            S_SH_R: begin
                w_z_re    = 1'b1;
                w_z_raddr = r_idx + SW'(1);
            end
            S_HT_R: begin
                w_r_re = 1'b1;
            end
            S_SH_W: begin
                w_z_we = 1'b1;
            end
            S_SH_F: begin
                w_z_we    = (r_op == OP_LIFT);
                w_z_waddr = SW'(r_count - CW'(1));
                w_z_wdata = r_tgt;
            end
            S_CR: begin
                w_z_we    = !r_used[r_idx];
                w_r_we    = !r_used[r_idx];
                w_z_waddr = SW'(r_count);
                w_z_wdata = r_idx;
            end
            default: begin
                w_z_re = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_count      = r_count;
        n_used       = r_used;
        n_op         = r_op;
        n_tgt        = r_tgt;
        n_new        = r_new;
        n_res_status = r_res_status;
        n_res_hit    = r_res_hit;
        n_res_slot   = r_res_slot;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op         = i_opcode;
                    n_tgt        = SW'(i_slot);
                    n_new.x0     = i_coord_x;
                    n_new.y0     = i_coord_y;
                    n_new.w      = i_size_w;
                    n_new.h      = i_size_h;
                    n_res_status = ST_OK;
                    n_res_hit    = 1'b0;
                    n_res_slot   = '0;
                    n_state      = S_RESP;
                    case (i_opcode)
                        OP_HIT: begin
                            n_idx   = SW'(r_count - CW'(1));
                            n_state = S_HT_Z;
                        end
                        OP_CREATE: begin
                            if (32'(r_count) >= MAX_WINDOWS) begin
                                n_res_status = ST_FULL;
                            end else begin
                                n_idx   = SW'(1);
                                n_state = S_CR;
                            end
                        end
                        OP_LIFT, OP_REMOVE: begin
                            if (w_tgt_bad) begin
                                n_res_status = ST_BAD;
                            end else begin
                                n_idx   = SW'(1);
                                n_state = S_FD_Z;
                            end
                        end
                        OP_CLEAR: begin
                            n_used  = MAX_WINDOWS'(1);
                            n_count = CW'(1);
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_HT_Z: begin
                n_state = S_HT_R;
            end
            S_HT_R: begin
                n_state = S_HT_C;
            end
            S_HT_C: begin
                if (w_inside) begin
                    n_res_hit  = 1'b1;
                    n_res_slot = r_zq;
                    n_state    = S_RESP;
                end else if (r_idx == '0) begin
                    n_state = S_RESP;
                end else begin
                    n_idx   = r_idx - SW'(1);
                    n_state = S_HT_Z;
                end
            end
            S_CR: begin
                if (!r_used[r_idx]) begin
                    n_used[r_idx] = 1'b1;
                    n_count       = r_count + CW'(1);
                    n_res_slot    = r_idx;
                    n_state       = S_RESP;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            S_FD_Z: begin
                n_state = S_FD_C;
            end
            S_FD_C: begin
                if (r_zq == r_tgt) begin
                    n_state = w_more ? S_SH_R : S_SH_F;
                end else if (!w_more) begin
                    n_res_status = ST_BAD;
                    n_state      = S_RESP;
                end else begin
                    n_idx   = r_idx + SW'(1);
                    n_state = S_FD_Z;
                end
            end
            S_SH_R: begin
                n_state = S_SH_W;
            end
            S_SH_W: begin
                n_idx   = r_idx + SW'(1);
                n_state = (((CW'(r_idx) + CW'(2)) < r_count)) ? S_SH_R : S_SH_F;
            end
            S_SH_F: begin
                if (r_op == OP_REMOVE) begin
                    n_count        = r_count - CW'(1);
                    n_used[r_tgt]  = 1'b0;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= CW'(1);
            r_used   <= MAX_WINDOWS'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_used  <= n_used;
            if (w_out_free) begin
                r_ovalid <= (r_state == S_RESP);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_op         <= n_op;
        r_tgt        <= n_tgt;
        r_new        <= n_new;
        r_res_status <= n_res_status;
        r_res_hit    <= n_res_hit;
        r_res_slot   <= n_res_slot;
        if (w_out_free && (r_state == S_RESP)) begin
            r_ostatus <= r_res_status;
            r_ohit    <= r_res_hit;
            r_oslot   <= SLOT_W'(r_res_slot);
        end
    end

    // The root is never stored: stack position 0 and slot 0 read as the root.
    always_ff @(posedge i_clk) begin
        if (w_z_we) begin
            zmem[w_z_waddr] <= w_z_wdata;
        end
        if (w_z_re) begin
            r_zq <= (w_z_raddr == '0) ? '0 : zmem[w_z_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_r_we) begin
            rmem[r_idx] <= r_new;
        end
        if (w_r_re) begin
            r_rq <= (r_zq == '0) ? '0 : rmem[r_zq];
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_hit         = r_ohit;
    assign o_result_slot = r_oslot;

endmodule

// File: src/wzht_checker.sv
// Port-level checks for the window z-order hit test block, bound to its top level.
// Depends on wzht_pkg and window_zorder_hit_test_top.
module wzht_checker
    import wzht_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [STATUS_W-1:0]       o_status,
    input logic                      o_hit,
    input logic [SLOT_W-1:0]         o_result_slot
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_hit) &&
        $stable(o_result_slot))
        else $error("Stalled result item changed.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("Block took no time after accepting an item.");

    a_hit_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> (o_status == ST_OK))
        else $error("Hit reported with an error status.");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> !o_hit && (o_result_slot == '0))
        else $error("Failed item carries a slot or a hit.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK) || (o_status == ST_FULL) || (o_status == ST_BAD))
        else $error("Result status outside the defined codes.");

endmodule

bind window_zorder_hit_test_top wzht_checker u_wzht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_hit         (o_hit),
    .o_result_slot (o_result_slot)
);

// File: test/window_zorder_hit_test_top_tb.sv
// Self-checking testbench for window_zorder_hit_test_top: directed and random commands.
// A built-in window stack model predicts every result; random idling on both sides.
// Depends on wzht_pkg and window_zorder_hit_test_top.
`timescale 1ns / 100ps

module window_zorder_hit_test_top_tb;
    import wzht_pkg::*;

    localparam int NWIN = MAX_WINDOWS_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_AT = 300;
    localparam int HOLD_LEN = 250;

    typedef struct {
        logic [OPC_W-1:0]          opcode;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
        int                        gap;
    } t_window_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                hit;
        logic [SLOT_W-1:0]   slot;
    } t_window_reply;

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [OPC_W-1:0]          i_opcode = '0;
    logic [SLOT_W-1:0]         i_slot = '0;
    logic signed [COORD_W-1:0] i_coord_x = '0;
    logic signed [COORD_W-1:0] i_coord_y = '0;
    logic [SIZE_W-1:0]         i_size_w = '0;
    logic [SIZE_W-1:0]         i_size_h = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [STATUS_W-1:0]       o_status;
    logic                      o_hit;
    logic [SLOT_W-1:0]         o_result_slot;

    t_window_cmd   cmd_pending[$];
    t_window_reply reply_expected[$];
    t_window_cmd   next_cmd;
    t_window_reply predicted;

    t_rect             win_rect[NWIN];
    bit                win_used[NWIN];
    logic [SLOT_W-1:0] stack_slot[NWIN];
    int                stack_depth;

    int gap_left = 0;
    int hold_left = 0;
    int hold_next;
    int n_replies = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    window_zorder_hit_test_top #(
        .MAX_WINDOWS(NWIN)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_opcode(i_opcode),
        .i_slot(i_slot),
        .i_coord_x(i_coord_x),
        .i_coord_y(i_coord_y),
        .i_size_w(i_size_w),
        .i_size_h(i_size_h),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_hit(o_hit),
        .o_result_slot(o_result_slot)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void stack_reset();
        for (int s = 0; s < NWIN; s++) begin
            win_rect[s] = '0;
            win_used[s] = 1'b0;
            stack_slot[s] = '0;
        end
        win_used[0] = 1'b1;
        stack_depth = 1;
    endfunction

    function automatic void stack_apply(input logic [OPC_W-1:0] op,
                                        input logic [SLOT_W-1:0] tgt,
                                        input logic signed [COORD_W-1:0] x,
                                        input logic signed [COORD_W-1:0] y,
                                        input logic [SIZE_W-1:0] w,
                                        input logic [SIZE_W-1:0] h,
                                        output t_window_reply r);
        int cx;
        int cy;
        int x0;
        int y0;
        int s;
        int p;
        bit found;
        cx = int'(x);
        cy = int'(y);
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_HIT: begin
                for (p = stack_depth - 1; p >= 0; p--) begin
                    s = int'(stack_slot[p]);
                    x0 = int'(signed'(win_rect[s].x0));
                    y0 = int'(signed'(win_rect[s].y0));
                    if (x0 <= cx && cx <= x0 + int'(win_rect[s].w) &&
                        y0 <= cy && cy <= y0 + int'(win_rect[s].h)) begin
                        r.hit = 1'b1;
                        r.slot = SLOT_W'(s);
                        break;
                    end
                end
            end
            OP_CREATE: begin
                found = 1'b0;
                if (stack_depth < NWIN) begin
                    for (s = 1; s < NWIN; s++) begin
                        if (!win_used[s]) begin
                            found = 1'b1;
                            break;
                        end
                    end
                end
                if (!found) begin
                    r.status = ST_FULL;
                end else begin
                    win_rect[s].x0 = x;
                    win_rect[s].y0 = y;
                    win_rect[s].w = w;
                    win_rect[s].h = h;
                    win_used[s] = 1'b1;
                    stack_slot[stack_depth] = SLOT_W'(s);
                    stack_depth++;
                    r.slot = SLOT_W'(s);
                end
            end
            OP_LIFT, OP_REMOVE: begin
                if (tgt == 0 || int'(tgt) >= NWIN || !win_used[tgt]) begin
                    r.status = ST_BAD;
                end else begin
                    for (p = 0; p < stack_depth; p++) begin
                        if (stack_slot[p] == tgt) break;
                    end
                    if (p >= stack_depth) begin
                        r.status = ST_BAD;
                    end else begin
                        for (; p + 1 < stack_depth; p++) begin
                            stack_slot[p] = stack_slot[p + 1];
                        end
                        if (op == OP_LIFT) begin
                            stack_slot[stack_depth - 1] = tgt;
                        end else begin
                            stack_depth--;
                            win_used[tgt] = 1'b0;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                for (s = 1; s < NWIN; s++) begin
                    win_used[s] = 1'b0;
                end
                stack_slot[0] = '0;
                stack_depth = 1;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic add_cmd(input logic [OPC_W-1:0] op, input int tgt, input int x,
                           input int y, input int w, input int h);
        t_window_cmd c;
        int n;
        n = cmd_pending.size();
        c.opcode = op;
        c.slot = SLOT_W'(tgt);
        c.x = COORD_W'(x);
        c.y = COORD_W'(y);
        c.w = SIZE_W'(w);
        c.h = SIZE_W'(h);
        if (n >= 500 && n < 560) begin
            c.gap = 0;
        end else begin
            c.gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 8));
        end
        cmd_pending.push_back(c);
    endtask

    function automatic int rand_coord();
        if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, 200)) - 80;
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic int rand_size();
        if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, 80));
        return int'($urandom_range(0, 2047));
    endfunction

    function automatic int rand_target();
        if ($urandom_range(0, 99) < 85) return int'($urandom_range(1, NWIN - 1));
        return int'($urandom_range(0, 15));
    endfunction

    task automatic build_stimulus();
        int pick;
        add_cmd(OP_HIT, 0, 0, 0, 0, 0);
        add_cmd(OP_HIT, 0, 1, 0, 0, 0);
        add_cmd(OP_CREATE, 0, -2048, -2048, 2047, 2047);
        add_cmd(OP_HIT, 0, -1, -1, 0, 0);
        add_cmd(OP_CREATE, 15, 2047, 2047, 2047, 2047);
        add_cmd(OP_HIT, 0, 2047, 2047, 0, 0);
        for (int k = 3; k < NWIN; k++) begin
            add_cmd(OP_CREATE, 0, 10 * k, -10 * k, k * 3, 0);
        end
        add_cmd(OP_CREATE, 0, 0, 0, 5, 5);
        add_cmd(OP_LIFT, NWIN - 1, 0, 0, 0, 0);
        add_cmd(OP_LIFT, 1, 0, 0, 0, 0);
        add_cmd(OP_LIFT, 0, 0, 0, 0, 0);
        add_cmd(OP_REMOVE, 2, 0, 0, 0, 0);
        add_cmd(OP_REMOVE, 2, 0, 0, 0, 0);
        add_cmd(OP_LIFT, 2, 0, 0, 0, 0);
        add_cmd(OP_HIT, 0, 2047, 2047, 0, 0);
        add_cmd(OP_CLEAR, 0, 0, 0, 0, 0);
        for (int k = 1; k <= 3; k++) begin
            add_cmd(OPC_W'(int'(OP_CLEAR) + k), 15, -1, -1, 2047, 2047);
        end
        add_cmd(OP_CREATE, 0, 0, 0, 0, 0);
        add_cmd(OP_HIT, 0, 0, 0, 0, 0);

        for (int i = 0; i < 750; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                add_cmd(OP_HIT, $urandom_range(0, 15), rand_coord(), rand_coord(),
                        $urandom_range(0, 2047), $urandom_range(0, 2047));
            end else if (pick < 62) begin
                add_cmd(OP_CREATE, $urandom_range(0, 15), rand_coord(), rand_coord(),
                        rand_size(), rand_size());
            end else if (pick < 75) begin
                add_cmd(OP_LIFT, rand_target(), rand_coord(), rand_coord(), 0, 0);
            end else if (pick < 88) begin
                add_cmd(OP_REMOVE, rand_target(), rand_coord(), rand_coord(), 0, 0);
            end else if (pick < 91) begin
                add_cmd(OP_CLEAR, $urandom_range(0, 15), 0, 0, 0, 0);
            end else if (pick < 95) begin
                add_cmd(OPC_W'(int'(OP_CLEAR) + $urandom_range(1, 3)), rand_target(),
                        rand_coord(), rand_coord(), rand_size(), rand_size());
            end else begin
                add_cmd(OP_HIT, 0, int'($urandom_range(0, 4095)) - 2048,
                        int'($urandom_range(0, 4095)) - 2048, 0, 0);
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: item %0d: %s", $time, n_replies, msg);
        mismatches++;
    endtask

    task automatic check_reply();
        t_window_reply want;
        if (reply_expected.size() == 0) begin
            report_mismatch("result with no pending item");
            return;
        end
        want = reply_expected.pop_front();
        if (o_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", o_status, want.status));
        if (o_hit !== want.hit)
            report_mismatch($sformatf("hit %0d, expected %0d", o_hit, want.hit));
        if (o_result_slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", o_result_slot, want.slot));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left <= 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                stack_apply(i_opcode, i_slot, i_coord_x, i_coord_y, i_size_w, i_size_h,
                            predicted);
                reply_expected.push_back(predicted);
            end
            if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_pending.size() > 0) begin
                next_cmd = cmd_pending.pop_front();
                i_opcode <= next_cmd.opcode;
                i_slot <= next_cmd.slot;
                i_coord_x <= next_cmd.x;
                i_coord_y <= next_cmd.y;
                i_size_w <= next_cmd.w;
                i_size_h <= next_cmd.h;
                i_valid <= 1'b1;
                gap_left <= next_cmd.gap;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_left <= 0;
        end else begin
            hold_next = hold_left;
            if (o_valid && !i_stall) begin
                check_reply();
                n_replies++;
                if (n_replies == HOLD_AT) begin
                    hold_next = HOLD_LEN;
                end else if (n_replies >= 100 && n_replies < 160) begin
                    hold_next = 0;
                end else begin
                    hold_next = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 8));
                end
            end else if (hold_next > 0) begin
                hold_next = hold_next - 1;
            end
            hold_left <= hold_next;
            i_stall <= (hold_next > 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        stack_reset();
        build_stimulus();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (cmd_pending.size() > 0 || i_valid || reply_expected.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (64) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
